[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define OEL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define OEL_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define OEL_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/oel_pkg.sv]
// ---------------------------------------------------------------------------
// oel_pkg
// types, constants and helpers of the event log ring
// ---------------------------------------------------------------------------
package oel_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned MAX_W      = 7;
  localparam int unsigned MAX_OUT    = 64;
  localparam int unsigned CMP_W      = (CNT_W > MAX_W) ? CNT_W : MAX_W;

  typedef enum logic {
    CMD_LOG  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [31:0] hook_id;
    logic [31:0] process_id;
    logic [63:0] time_stamp;
    logic [63:0] caller_address;
    logic [63:0] return_value;
    logic [31:0] action_code;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    logic we;
    ptr_t waddr;
    logic re;
    ptr_t raddr;
  } ram_ctrl_t;

  typedef struct packed {
    logic load;
    logic has_entry;
    logic last;
  } load_t;

  function automatic ptr_t next_ptr(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

[design/oel_if.sv]
// ---------------------------------------------------------------------------
// oel_if
// valid/ready channels of the event log: command beats in, result beats out
// ---------------------------------------------------------------------------
interface oel_in_if import oel_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] hook_id;
  logic [31:0] process_id;
  logic [63:0] time_stamp;
  logic [63:0] caller_address;
  logic [63:0] return_value;
  logic [31:0] action_code;
  logic [MAX_W-1:0] max_entries;

  modport source (
    output valid, cmd, hook_id, process_id, time_stamp, caller_address,
           return_value, action_code, max_entries,
    input  ready
  );
  modport sink (
    input  valid, cmd, hook_id, process_id, time_stamp, caller_address,
           return_value, action_code, max_entries,
    output ready
  );
endinterface

interface oel_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] out_hook_id;
  logic [31:0] out_process_id;
  logic [63:0] out_time_stamp;
  logic [63:0] out_caller_address;
  logic [63:0] out_return_value;
  logic [31:0] out_action_code;
  logic        has_entry;
  logic        last;

  modport source (
    output valid, out_hook_id, out_process_id, out_time_stamp, out_caller_address,
           out_return_value, out_action_code, has_entry, last,
    input  ready
  );
  modport sink (
    input  valid, out_hook_id, out_process_id, out_time_stamp, out_caller_address,
           out_return_value, out_action_code, has_entry, last,
    output ready
  );
endinterface

[design/oel_ram.sv]
// ---------------------------------------------------------------------------
// oel_ram
// single write port, single read port memory with registered read data
// ---------------------------------------------------------------------------
module oel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/oel_ctrl.sv]
// ---------------------------------------------------------------------------
// oel_ctrl
// ring pointers, fill count and the drain sequencer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module oel_ctrl import oel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             cmd_i,
  input  logic [MAX_W-1:0] max_entries_i,
  input  logic             out_free_i,
  output logic             in_ready_o,
  output ram_ctrl_t        ram_o,
  output load_t            load_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_HOLD  = 4'b0100,
    ST_NULL  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  ptr_t             wr_ptr_q, wr_ptr_d;
  ptr_t             rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAX_W-1:0] left_q, left_d;
  logic [MAX_W-1:0] want;
  logic [MAX_W-1:0] n_drain;
  ptr_t             rd_ptr_inc;
  logic             acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i & in_ready_o;
  assign rd_ptr_inc = next_ptr(rd_ptr_q);

  always_comb begin
    want = (max_entries_i > MAX_W'(MAX_OUT)) ? MAX_W'(MAX_OUT) : max_entries_i;
    if (CMP_W'(want) < CMP_W'(cnt_q)) begin
      n_drain = want;
    end else begin
      n_drain = MAX_W'(cnt_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    ram_o.we    = 1'b0;
    ram_o.waddr = wr_ptr_q;
    ram_o.re    = 1'b0;
    ram_o.raddr = rd_ptr_q;
    load_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (cmd_i == CMD_LOG) begin
            ram_o.we = 1'b1;
            wr_ptr_d = next_ptr(wr_ptr_q);
            if (cnt_q < CNT_W'(RING_DEPTH)) begin
              cnt_d = cnt_q + CNT_W'(1);
            end else begin
              rd_ptr_d = rd_ptr_inc;
            end
          end else if (n_drain == '0) begin
            state_d = ST_NULL;
          end else begin
            ram_o.re = 1'b1;
            left_d   = n_drain;
            state_d  = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free_i) begin
          load_o.load      = 1'b1;
          load_o.has_entry = 1'b1;
          load_o.last      = (left_q == MAX_W'(1));
          rd_ptr_d         = rd_ptr_inc;
          cnt_d            = cnt_q - CNT_W'(1);
          left_d           = left_q - MAX_W'(1);
          if (left_q == MAX_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ram_o.re    = 1'b1;
            ram_o.raddr = rd_ptr_inc;
            state_d     = ST_FETCH;
          end
        end
      end
      ST_NULL: begin
        if (out_free_i) begin
          load_o.load = 1'b1;
          load_o.last = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      left_q   <= '0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
    end
  end

  `OEL_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(RING_DEPTH), "fill count beyond ring depth")
  `OEL_ASSERT_IMP(a_ptr_meet, (cnt_q == '0) || (cnt_q == CNT_W'(RING_DEPTH)), rd_ptr_q == wr_ptr_q, "pointers apart on empty or full ring")
  `OEL_ASSERT_IMP(a_load_free, load_o.load, out_free_i, "result loaded over a held beat")
  `OEL_ASSERT_NXT(a_last_idle, load_o.load && load_o.last, state_q == ST_IDLE, "sequencer busy after last beat")

endmodule

[design/overwrite_oldest_event_log.sv]
// ---------------------------------------------------------------------------
// overwrite_oldest_event_log
// event trace ring that overwrites its oldest record when full
// ---------------------------------------------------------------------------
//  port   dir  beat
//  ev_i   in   log record or read request (cmd, max_entries)
//  ev_o   out  drained record, has_entry and last flags
//
//  a log writes the ram as it is taken; the next command is taken the cycle after
//  a read drains each record in order, in steps: one ram read,
//    then the load into the output register
//  a read of nothing gives one empty beat
//  reset clears pointers, fill count and control state, not the ram; no clearing pass
//  a stalled output holds the drain sequencer in place
// ---------------------------------------------------------------------------
module overwrite_oldest_event_log import oel_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  oel_in_if.sink    ev_i,
  oel_out_if.source ev_o
);

  ram_ctrl_t        ram_ctrl;
  load_t            ld;
  rec_t             wr_rec;
  logic [REC_W-1:0] rd_data;
  rec_t             out_rec_q;
  logic             out_valid_q;
  logic             out_has_q;
  logic             out_last_q;
  logic             out_free;

  assign out_free = !out_valid_q || ev_o.ready;

  assign wr_rec.hook_id        = ev_i.hook_id;
  assign wr_rec.process_id     = ev_i.process_id;
  assign wr_rec.time_stamp     = ev_i.time_stamp;
  assign wr_rec.caller_address = ev_i.caller_address;
  assign wr_rec.return_value   = ev_i.return_value;
  assign wr_rec.action_code    = ev_i.action_code;

  oel_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (ev_i.valid),
    .cmd_i         (ev_i.cmd),
    .max_entries_i (ev_i.max_entries),
    .out_free_i    (out_free),
    .in_ready_o    (ev_i.ready),
    .ram_o         (ram_ctrl),
    .load_o        (ld)
  );

  oel_ram #(
    .Width (REC_W),
    .Depth (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_ctrl.we),
    .waddr_i (ram_ctrl.waddr),
    .wdata_i (wr_rec),
    .re_i    (ram_ctrl.re),
    .raddr_i (ram_ctrl.raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld.load) begin
      out_valid_q <= 1'b1;
    end else if (ev_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld.load) begin
      out_rec_q  <= ld.has_entry ? rec_t'(rd_data) : rec_t'('0);
      out_has_q  <= ld.has_entry;
      out_last_q <= ld.last;
    end
  end

  assign ev_o.valid              = out_valid_q;
  assign ev_o.out_hook_id        = out_rec_q.hook_id;
  assign ev_o.out_process_id     = out_rec_q.process_id;
  assign ev_o.out_time_stamp     = out_rec_q.time_stamp;
  assign ev_o.out_caller_address = out_rec_q.caller_address;
  assign ev_o.out_return_value   = out_rec_q.return_value;
  assign ev_o.out_action_code    = out_rec_q.action_code;
  assign ev_o.has_entry          = out_has_q;
  assign ev_o.last               = out_last_q;

endmodule
